@@ design/ultrasonic_frame_filter_top_defines.svh @@
// ---------------------------------------------------------------------------
// Ultrasonic frame filter assertion macros
// Shared concurrent assertion forms for the frame filter modules.
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_FRAME_FILTER_TOP_DEFINES_SVH
`define ULTRASONIC_FRAME_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define UFF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uff assertion failed");

// Next-cycle implication, checked out of reset
`define UFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uff assertion failed");

`endif

@@ design/uff_pkg.sv @@
// ---------------------------------------------------------------------------
// Ultrasonic frame filter package
// Shared types and register indexes for the frame filter.
// ---------------------------------------------------------------------------
package uff_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_SAFE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 3'd4;

    localparam logic [8:0] ALPHA_ONE = 9'd256;

    typedef struct packed {
        logic [8:0]  alpha_q8;
        logic [7:0]  start_marker;
        logic [15:0] fail_safe_mm;
        logic [15:0] min_range_mm;
        logic [15:0] max_range_mm;
    } cfg_t;

    // One checked frame on its way to the filter
    typedef struct packed {
        logic        bad;
        logic [15:0] dist_mm;
        logic        used;
    } frame_t;

    typedef enum logic [1:0] {
        POS_HUNT,
        POS_HIGH,
        POS_LOW,
        POS_SUM
    } pos_t;

endpackage

@@ design/uff_front.sv @@
// ---------------------------------------------------------------------------
// Ultrasonic frame filter front end
// Hunts for the start byte, gathers a frame and checks its checksum.
// ---------------------------------------------------------------------------
`include "ultrasonic_frame_filter_top_defines.svh"

module uff_front
    import uff_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  logic [7:0]  rx_byte,
    input  logic        q_full,
    output logic        in_stall,
    output logic        push,
    output frame_t      push_data
);

    pos_t        pos_reg;
    pos_t        pos_next;
    logic [7:0]  high_reg;
    logic [7:0]  low_reg;
    logic        accept;
    logic [7:0]  sum;
    logic [15:0] dist_mm;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            unique case (pos_reg)
                POS_HUNT: pos_next = (rx_byte == cfg.start_marker) ? POS_HIGH : POS_HUNT;
                POS_HIGH: pos_next = POS_LOW;
                POS_LOW:  pos_next = POS_SUM;
                POS_SUM:  pos_next = POS_HUNT;
                default:  pos_next = POS_HUNT;
            endcase
        end
    end

    always_comb
    begin
        sum       = cfg.start_marker + high_reg + low_reg;
        dist_mm   = {high_reg, low_reg};
        push      = 1'b0;
        push_data = '0;
        unique case (pos_reg)
            POS_SUM:
            begin
                push = accept;
                if (rx_byte != sum)
                begin
                    push_data.bad = 1'b1;
                end
                else if (dist_mm == 16'd0)
                begin
                    // substitute the fail-safe distance
                    push_data.dist_mm = cfg.fail_safe_mm;
                    push_data.used    = 1'b1;
                end
                else
                begin
                    push_data.dist_mm = dist_mm;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_HUNT;
            high_reg <= '0;
            low_reg  <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (accept && pos_reg == POS_HIGH)
            begin
                high_reg <= rx_byte;
            end
            if (accept && pos_reg == POS_LOW)
            begin
                low_reg <= rx_byte;
            end
        end
    end

    `UFF_ASSERT_NEXT(a_push_rehunts, clk, rst_n, push, pos_reg == POS_HUNT)
    `UFF_ASSERT_NOW(a_bad_clean, clk, rst_n, push && push_data.bad,
                    push_data.dist_mm == 16'd0 && !push_data.used)

endmodule

@@ design/uff_queue.sv @@
// ---------------------------------------------------------------------------
// Ultrasonic frame filter queue
// Short FIFO of checked frames between the front end and the filter.
// ---------------------------------------------------------------------------
`include "ultrasonic_frame_filter_top_defines.svh"

module uff_queue
    import uff_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_data,
    input  logic   pop,
    output frame_t pop_data,
    output logic   full,
    output logic   empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    frame_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    `UFF_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full)
    `UFF_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !empty)

endmodule

@@ design/uff_back.sv @@
// ---------------------------------------------------------------------------
// Ultrasonic frame filter back end
// Low-pass filter update, result register and range clamp.
// ---------------------------------------------------------------------------
`include "ultrasonic_frame_filter_top_defines.svh"

module uff_back
    import uff_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_empty,
    input  frame_t      q_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [15:0] raw_distance_mm,
    output logic        fail_safe_used,
    output logic [15:0] range_mm
);

    logic [23:0]        filt_reg;
    logic [23:0]        filt_next;
    logic               valid_reg;
    logic               status_reg;
    logic [15:0]        raw_reg;
    logic               used_reg;
    logic [15:0]        level_reg;
    logic [8:0]         alpha;
    logic signed [25:0] diff;
    logic signed [35:0] prod;
    logic signed [35:0] step;
    logic signed [25:0] sum;
    logic [15:0]        low_clamped;

    assign pop = !q_empty && (!valid_reg || !out_stall);

    // filtered += floor(alpha * (d*256 - filtered) / 256)
    always_comb
    begin
        alpha     = cfg.alpha_q8[8] ? ALPHA_ONE : cfg.alpha_q8;
        diff      = $signed({2'b00, q_data.dist_mm, 8'h00}) - $signed({2'b00, filt_reg});
        prod      = $signed({{10{diff[25]}}, diff}) * $signed({27'd0, alpha});
        step      = prod >>> 8;
        sum       = $signed({2'b00, filt_reg}) + step[25:0];
        filt_next = sum[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= 1'b1;
                if (!q_data.bad)
                begin
                    filt_reg <= filt_next;
                end
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= q_data.bad;
            raw_reg    <= q_data.dist_mm;
            used_reg   <= q_data.used;
            level_reg  <= q_data.bad ? 16'd0 : filt_next[23:8];
        end
    end

    // apply the minimum first, then the maximum
    always_comb
    begin
        low_clamped = (level_reg < cfg.min_range_mm) ? cfg.min_range_mm : level_reg;
        range_mm    = (low_clamped > cfg.max_range_mm) ? cfg.max_range_mm : low_clamped;
        if (status_reg)
        begin
            range_mm = 16'd0;
        end
    end

    assign out_valid       = valid_reg;
    assign status          = status_reg;
    assign raw_distance_mm = raw_reg;
    assign fail_safe_used  = used_reg;

    `UFF_ASSERT_NEXT(a_bad_keeps_filter, clk, rst_n, pop && q_data.bad, $stable(filt_reg))
    `UFF_ASSERT_NOW(a_fail_safe_value, clk, rst_n, valid_reg && used_reg,
                    raw_reg == cfg.fail_safe_mm && !status_reg)

endmodule

@@ design/ultrasonic_frame_filter_top.sv @@
// Each frame's result passes through the frame queue and then the result register before it reaches the output.
// Throughput: one byte per cycle; the filter state feeds back through one multiply-add.
// Bytes stall only while the frame queue (QUEUE_DEPTH entries, two by default) is full.
// Reset (rst_n low, asynchronous): hunt for a start byte, empty queue, filter state zero,
// registers back to their defaults. No clearing pass.
// ---------------------------------------------------------------------------
// Ultrasonic frame filter top level
// Frame checker, frame queue and low-pass filter with configuration registers.
// ---------------------------------------------------------------------------
module ultrasonic_frame_filter_top
    import uff_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  status,
    output logic [15:0]           raw_distance_mm,
    output logic                  fail_safe_used,
    output logic [15:0]           range_mm
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   push;
    frame_t push_data;
    logic   pop;
    frame_t pop_data;
    logic   q_full;
    logic   q_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_ALPHA:     cfg_next.alpha_q8     = cfg_wdata[8:0];
                CFG_START:     cfg_next.start_marker = cfg_wdata[7:0];
                CFG_FAIL_SAFE: cfg_next.fail_safe_mm = cfg_wdata;
                CFG_MIN_RANGE: cfg_next.min_range_mm = cfg_wdata;
                CFG_MAX_RANGE: cfg_next.max_range_mm = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_q8     <= 9'd128;
            cfg_reg.start_marker <= 8'd255;
            cfg_reg.fail_safe_mm <= 16'd6000;
            cfg_reg.min_range_mm <= 16'd200;
            cfg_reg.max_range_mm <= 16'd4000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    uff_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .in_stall  (in_stall),
        .push      (push),
        .push_data (push_data)
    );

    uff_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    uff_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_empty         (q_empty),
        .q_data          (pop_data),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .raw_distance_mm (raw_distance_mm),
        .fail_safe_used  (fail_safe_used),
        .range_mm        (range_mm)
    );

endmodule

@@ bench/ultrasonic_frame_filter_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ultrasonic frame filter testbench
// Feeds serial bytes (directed frames, then random frames, bad checksums and
// noise) through several register settings and idle patterns, predicts each
// frame result and the low-pass filter state, and checks every result.
// ---------------------------------------------------------------------------
module ultrasonic_frame_filter_top_tb
    import uff_pkg::*;
;

    localparam logic FRAME_OK      = 1'b0;
    localparam logic FRAME_BAD_SUM = 1'b1;

    localparam int          SETTLE_CYCLES  = 8;
    localparam int          NUM_PHASES     = 12;
    localparam int          BYTES_PER_PHASE = 100;
    localparam int unsigned LIMIT_NS       = 5_000_000;

    typedef struct packed {
        logic        status;
        logic [15:0] raw_distance_mm;
        logic        fail_safe_used;
        logic [15:0] range_mm;
    } range_result_t;

    class range_scoreboard;
        cfg_t            regs;
        pos_t            pos;
        logic [7:0]      hi_byte;
        logic [7:0]      lo_byte;
        logic [23:0]     filt_q8;
        range_result_t   expected_q[$];
        int              errors;

        function new();
            regs.alpha_q8     = 9'd128;
            regs.start_marker = 8'hFF;
            regs.fail_safe_mm = 16'd6000;
            regs.min_range_mm = 16'd200;
            regs.max_range_mm = 16'd4000;
            pos     = POS_HUNT;
            hi_byte = '0;
            lo_byte = '0;
            filt_q8 = '0;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ALPHA:     regs.alpha_q8     = val[8:0];
                CFG_START:     regs.start_marker = val[7:0];
                CFG_FAIL_SAFE: regs.fail_safe_mm = val;
                CFG_MIN_RANGE: regs.min_range_mm = val;
                CFG_MAX_RANGE: regs.max_range_mm = val;
                default: ;
            endcase
        endfunction

        // Advance the frame parser by one accepted byte; queue a result on the checksum byte
        function void note_byte(logic [7:0] b);
            range_result_t res;
            logic [15:0]   d;
            logic [8:0]    a;
            longint        diff;
            longint        nxt;
            logic [15:0]   r;
            case (pos)
                POS_HUNT:
                begin
                    if (b == regs.start_marker)
                        pos = POS_HIGH;
                end
                POS_HIGH:
                begin
                    hi_byte = b;
                    pos = POS_LOW;
                end
                POS_LOW:
                begin
                    lo_byte = b;
                    pos = POS_SUM;
                end
                default:
                begin
                    pos = POS_HUNT;
                    res = '0;
                    if (b != 8'(regs.start_marker + hi_byte + lo_byte))
                    begin
                        // keep the filter state, report the mismatch only
                        res.status = FRAME_BAD_SUM;
                    end
                    else
                    begin
                        res.status = FRAME_OK;
                        d = {hi_byte, lo_byte};
                        if (d == 16'd0)
                        begin
                            d = regs.fail_safe_mm;
                            res.fail_safe_used = 1'b1;
                        end
                        a = (regs.alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : regs.alpha_q8;
                        diff = longint'(d) * 256 - longint'(filt_q8);
                        // arithmetic shift floors toward minus infinity
                        nxt = longint'(filt_q8) + ((longint'(a) * diff) >>> 8);
                        if (nxt < 0)
                            nxt = 0;
                        if (nxt > 64'h00FF_FFFF)
                            nxt = 64'h00FF_FFFF;
                        filt_q8 = nxt[23:0];
                        r = filt_q8[23:8];
                        if (r < regs.min_range_mm)
                            r = regs.min_range_mm;
                        if (r > regs.max_range_mm)
                            r = regs.max_range_mm;
                        res.raw_distance_mm = d;
                        res.range_mm = r;
                    end
                    expected_q.push_back(res);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(range_result_t got);
            range_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got %p", $time, got);
            end
            else
            begin
                want = expected_q.pop_front();
                compare_field("status", 16'(want.status), 16'(got.status));
                compare_field("raw_distance_mm", want.raw_distance_mm, got.raw_distance_mm);
                compare_field("fail_safe_used", 16'(want.fail_safe_used),
                              16'(got.fail_safe_used));
                compare_field("range_mm", want.range_mm, got.range_mm);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic                  status;
    logic [15:0]           raw_distance_mm;
    logic                  fail_safe_used;
    logic [15:0]           range_mm;

    range_scoreboard sb;
    int unsigned     send_gap_pct = 0;
    int unsigned     stall_pct = 0;

    ultrasonic_frame_filter_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .raw_distance_mm (raw_distance_mm),
        .fail_safe_used  (fail_safe_used),
        .range_mm        (range_mm)
    );

    always #6 clk = ~clk;

    // Result side: check accepted items, then pick the stall for the next edge
    always @(posedge clk)
    begin
        range_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status          = status;
            got.raw_distance_mm = raw_distance_mm;
            got.fail_safe_used  = fail_safe_used;
            got.range_mm        = range_mm;
            sb.check_result(got);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] hi, input logic [7:0] lo,
                              input logic [7:0] sum_skew);
        logic [7:0] mark;
        mark = sb.regs.start_marker;
        send_byte(mark);
        send_byte(hi);
        send_byte(lo);
        send_byte(8'(mark + hi + lo + sum_skew));
    endtask

    // Hold until every expected result is out and the pipeline has settled
    task automatic drain();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic program_regs(input cfg_t c);
        drain();
        // junk in the unused upper bits must be ignored
        write_reg(CFG_ALPHA, {7'($urandom), c.alpha_q8});
        write_reg(CFG_START, {8'($urandom), c.start_marker});
        write_reg(CFG_FAIL_SAFE, c.fail_safe_mm);
        write_reg(CFG_MIN_RANGE, c.min_range_mm);
        write_reg(CFG_MAX_RANGE, c.max_range_mm);
        cfg_we <= 1'b0;
    endtask

    function automatic cfg_t pick_regs(int ph);
        cfg_t c;
        c.alpha_q8     = 9'($urandom_range(0, 511));
        c.start_marker = 8'($urandom);
        c.fail_safe_mm = 16'($urandom);
        c.min_range_mm = 16'($urandom_range(0, 2000));
        c.max_range_mm = 16'($urandom_range(1000, 65535));
        case (ph)
            0: c = '{alpha_q8: 9'd256, start_marker: 8'h00, fail_safe_mm: 16'd0,
                     min_range_mm: 16'd0, max_range_mm: 16'hFFFF};
            // minimum above maximum, frozen filter
            1: c = '{alpha_q8: 9'd0, start_marker: 8'hA5, fail_safe_mm: 16'hFFFF,
                     min_range_mm: 16'hFFFF, max_range_mm: 16'd0};
            // alpha beyond one saturates
            2: c = '{alpha_q8: 9'd511, start_marker: 8'hFF, fail_safe_mm: 16'd1234,
                     min_range_mm: 16'd100, max_range_mm: 16'd60000};
            3: c.alpha_q8 = 9'd1;
            7:
            begin
                c.min_range_mm = 16'($urandom);
                c.max_range_mm = 16'($urandom);
            end
            default: ;
        endcase
        return c;
    endfunction

    initial
    begin
        int          sent;
        int unsigned kind;
        logic [7:0]  hi;
        logic [7:0]  lo;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_idx   <= '0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        out_stall <= 1'b0;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under reset settings
        send_byte(8'h00);
        send_byte(8'h7F);
        send_frame(8'h00, 8'h00, 8'h00);   // zero distance takes the fail-safe value
        send_frame(8'hFF, 8'hFF, 8'h00);   // largest distance, start byte as data
        send_frame(8'h12, 8'h34, 8'h5A);   // checksum mismatch
        send_frame(8'h00, 8'h01, 8'h00);
        send_frame(8'h80, 8'hFF, 8'h00);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            in_valid <= 1'b0;
            program_regs(pick_regs(ph));
            case (ph % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 50; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 50; end
                default: begin send_gap_pct = 11; stall_pct = 11; end
            endcase
            sent = 0;
            while (sent < BYTES_PER_PHASE)
            begin
                kind = $urandom_range(99);
                if (kind < 10)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        send_byte(8'($urandom));
                        sent++;
                    end
                end
                else
                begin
                    hi = 8'($urandom);
                    lo = 8'($urandom);
                    case ($urandom_range(9))
                        0: begin hi = 8'h00; lo = 8'h00; end
                        1: begin hi = 8'hFF; lo = 8'hFF; end
                        default: ;
                    endcase
                    send_frame(hi, lo, (kind < 20) ? 8'($urandom_range(1, 255)) : 8'h00);
                    sent += 4;
                end
            end
        end

        in_valid <= 1'b0;
        drain();
        if (sb.errors == 0)
            $display("ultrasonic_frame_filter_top_tb: done, clean");
        else
            $display("ultrasonic_frame_filter_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("ultrasonic_frame_filter_top_tb: done, errors");
        $finish;
    end

endmodule

@@ ultrasonic_frame_filter_top.f @@
+incdir+design
design/uff_pkg.sv
design/uff_front.sv
design/uff_queue.sv
design/uff_back.sv
design/ultrasonic_frame_filter_top.sv
bench/ultrasonic_frame_filter_top_tb.sv
